### hw/rtl/htn_pkg.sv
// Shared types and constants for the hysteresis threshold unit.
package htn_pkg;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROW_W      = 16;
    localparam int WIDTH_CFG_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [PIX_W-1:0]       LOW_RESET    = 8'd50;
    localparam logic [PIX_W-1:0]       HIGH_RESET   = 8'd100;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_MIN    = 11'd3;
    localparam logic [ROW_W-1:0]       HEIGHT_MIN   = 16'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             bottom;
        logic             last;
    } beat_t;

endpackage

### hw/rtl/htn_linebuf.sv
// Line buffers: previous row values and older row strength flags.
module htn_linebuf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [htn_pkg::PIX_W-1:0]    wr_pix,
    input  logic                         wr_strong,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_pix_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_strong_addr,
    output logic [htn_pkg::PIX_W-1:0]    rd_pix,
    output logic                         rd_strong
);

    logic [htn_pkg::PIX_W-1:0] val_mem [MAX_WIDTH];
    logic                      strong_mem [MAX_WIDTH];
    logic [htn_pkg::PIX_W-1:0] rd_pix_reg;
    logic                      rd_strong_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            val_mem[wr_addr] <= wr_pix;
            rd_pix_reg       <= val_mem[rd_pix_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            strong_mem[wr_addr] <= wr_strong;
            rd_strong_reg       <= strong_mem[rd_strong_addr];
        end
    end

    assign rd_pix    = rd_pix_reg;
    assign rd_strong = rd_strong_reg;

endmodule

### hw/rtl/htn_out_fifo.sv
// Four-entry result queue taking up to two beats per cycle.
module htn_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push0,
    input  logic           push1,
    input  htn_pkg::beat_t data0,
    input  htn_pkg::beat_t data1,
    input  logic           pop,
    output htn_pkg::beat_t head,
    output logic           not_empty,
    output logic           room
);

    htn_pkg::beat_t fifo_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_cnt;

    always_comb begin
        push_cnt    = {1'b0, push0} + {1'b0, push1};
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            fifo_reg[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            fifo_reg[wr_ptr_reg + 2'd1] <= data1;
        end
    end

    assign head      = fifo_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd2);

endmodule

### hw/rtl/hysteresis_threshold_4n_unit.sv
// Hysteresis thresholding with 4-neighbor linking over a raster pixel stream.
// Each accepted pixel reads the line buffers one column ahead, so a pixel can be taken every
// cycle while the output queue has room: one result beat per pixel, delayed by one row (the
// first row gives none). On the last row of a frame each pixel gives two beats (the pixel above,
// then the bottom pixel itself), and the single output beat per cycle limits intake there. A
// result beat enters a four-beat queue when its pixel is accepted; the queue decouples the sides.
// Line buffer contents are undefined after reset and need no clearing pass.
module hysteresis_threshold_4n_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [htn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tuser,   // [0] is_bottom_row
    output logic                              m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = CW + 1;
    localparam int RW = htn_pkg::ROW_W;
    localparam int PW = htn_pkg::PIX_W;

    logic [PW-1:0]                   low_reg;
    logic [PW-1:0]                   high_reg;
    logic [htn_pkg::WIDTH_CFG_W-1:0] width_reg;
    logic [RW-1:0]                   height_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] upper_reg, upper_next;
    logic [PW-1:0] col0_reg, col0_next;
    logic          left_strong_reg, left_strong_next;

    logic [XW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [XW-1:0] col_inc;
    logic [RW:0]   row_inc;
    logic          wrap;
    logic          bottom;
    logic [CW-1:0] next_col;
    logic          accept;
    logic          has_main;
    logic          is_border;
    logic          upper_strong;
    logic          linked;
    logic [PW:0]   thr_sum;
    logic [PW-1:0] mid;
    logic [PW-1:0] pix;
    logic [PW-1:0] main_pix;
    logic [CW-1:0] rd_pix_addr;

    logic [PW-1:0] lb_rd_pix;
    logic          lb_rd_strong;

    htn_pkg::beat_t main_beat, bot_beat, q_data0, q_head;
    logic           q_push0, q_push1, q_pop, q_not_empty, q_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= htn_pkg::LOW_RESET;
            high_reg   <= htn_pkg::HIGH_RESET;
            width_reg  <= htn_pkg::WIDTH_RESET;
            height_reg <= htn_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                htn_pkg::CFG_LOW:    low_reg    <= cfg_wdata[PW-1:0];
                htn_pkg::CFG_HIGH:   high_reg   <= cfg_wdata[PW-1:0];
                htn_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[htn_pkg::WIDTH_CFG_W-1:0];
                htn_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = XW'(MAX_WIDTH);
        end else if (width_reg < htn_pkg::WIDTH_MIN) begin
            eff_w = XW'(htn_pkg::WIDTH_MIN);
        end else begin
            eff_w = XW'(width_reg);
        end
        eff_h = (height_reg < htn_pkg::HEIGHT_MIN) ? htn_pkg::HEIGHT_MIN : height_reg;
    end

    assign accept = s_tvalid && s_tready;
    assign pix    = s_tdata;

    always_comb begin
        col_inc  = {1'b0, col_reg} + XW'(1);
        wrap     = (col_inc >= eff_w);
        next_col = wrap ? '0 : col_inc[CW-1:0];
        row_inc  = {1'b0, row_reg} + (RW+1)'(1);
        bottom   = (row_inc >= {1'b0, eff_h});
        has_main = (row_reg != '0);
        rd_pix_addr = (next_col == CW'(MAX_WIDTH - 1)) ? '0 : next_col + CW'(1);

        thr_sum = {1'b0, low_reg} + {1'b0, high_reg};
        mid     = thr_sum[PW:1];

        upper_strong = (upper_reg >= high_reg);
        is_border    = (row_reg == RW'(1)) || (col_reg == '0) || wrap;
        linked       = lb_rd_strong || (pix >= high_reg) || left_strong_reg
                       || (lb_rd_pix >= high_reg);

        priority if (is_border) begin
            main_pix = (upper_reg <= mid) ? htn_pkg::PIX_OFF : htn_pkg::PIX_ON;
        end else if (upper_strong) begin
            main_pix = htn_pkg::PIX_ON;
        end else if (upper_reg <= low_reg) begin
            main_pix = htn_pkg::PIX_OFF;
        end else begin
            main_pix = linked ? htn_pkg::PIX_ON : htn_pkg::PIX_OFF;
        end

        main_beat.pixel  = main_pix;
        main_beat.bottom = 1'b0;
        main_beat.last   = !bottom;
        bot_beat.pixel   = (pix <= mid) ? htn_pkg::PIX_OFF : htn_pkg::PIX_ON;
        bot_beat.bottom  = 1'b1;
        bot_beat.last    = 1'b1;

        q_push0 = accept && (has_main || bottom);
        q_push1 = accept && has_main && bottom;
        q_data0 = has_main ? main_beat : bot_beat;
    end

    always_comb begin
        col_next         = col_reg;
        row_next         = row_reg;
        upper_next       = upper_reg;
        col0_next        = col0_reg;
        left_strong_next = left_strong_reg;
        if (accept) begin
            col_next         = next_col;
            left_strong_next = upper_strong;
            upper_next       = (next_col == '0) ? col0_reg : lb_rd_pix;
            if (col_reg == '0) begin
                col0_next = pix;
            end
            if (wrap) begin
                row_next = bottom ? '0 : row_inc[RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        upper_reg       <= upper_next;
        col0_reg        <= col0_next;
        left_strong_reg <= left_strong_next;
    end

    htn_linebuf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_linebuf (
        .aclk           (aclk),
        .en             (accept),
        .wr_addr        (col_reg),
        .wr_pix         (pix),
        .wr_strong      (upper_strong),
        .rd_pix_addr    (rd_pix_addr),
        .rd_strong_addr (next_col),
        .rd_pix         (lb_rd_pix),
        .rd_strong      (lb_rd_strong)
    );

    htn_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (q_push0),
        .push1     (q_push1),
        .data0     (q_data0),
        .data1     (bot_beat),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .room      (q_room)
    );

    assign q_pop    = q_not_empty && m_tready;
    assign s_tready = q_room;
    assign m_tvalid = q_not_empty;
    assign m_tdata  = q_head.pixel;
    assign m_tuser  = q_head.bottom;
    assign m_tlast  = q_head.last;

endmodule
